/* rtl/length_prefixed_frame_rx_buffer_macros.svh */
// Assertion macros used by the frame receive buffer checker.
`ifndef LENGTH_PREFIXED_FRAME_RX_BUFFER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RX_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LPFRX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPFRX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lpfrx_pkg.sv */
// Shared types and codes for the length-prefixed frame receive buffer.
`default_nettype none

package lpfrx_pkg;

   typedef enum logic [1:0] {
      REQ_RX_BYTE = 2'd0,
      REQ_READ    = 2'd1,
      REQ_FLUSH   = 2'd2
   } req_code_type;

   // Result fields known when the result is issued; data comes from the store.
   typedef struct packed {
      logic       status;
      logic [7:0] received_count;
      logic       data_valid;
      logic       last;
   } meta_type;

   typedef struct packed {
      logic       status;
      logic [7:0] received_count;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       last;
   } rsp_item_type;

endpackage

`default_nettype wire

/* rtl/lpfrx_mem.sv */
// Payload store: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module lpfrx_mem #(
   parameter int BUF_DEPTH = 64,
   localparam int PW = $clog2(BUF_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [PW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [PW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0]           mem [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] valid_ff;
   logic [7:0]           rd_data_ff;

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 8'h00;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/lpfrx_ctrl.sv */
// Frame bookkeeping and read sequencer: parses headers, writes payload, issues reads.
`default_nettype none

module lpfrx_ctrl #(
   parameter int BUF_DEPTH = 64,
   localparam int PW = $clog2(BUF_DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_type,
   input  wire logic [7:0]               req_rx_byte,
   input  wire logic [7:0]               req_read_size,
   input  wire logic                     room,
   output logic                          wr_en,
   output logic      [PW-1:0]            wr_addr,
   output logic      [7:0]               wr_data,
   output logic                          rd_en,
   output logic      [PW-1:0]            rd_addr,
   output logic                          meta_valid,
   output lpfrx_pkg::meta_type           meta
);

   typedef enum logic {ST_IDLE, ST_DELIVER} state_type;

   state_type           state_ff, state_in;
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [7:0]          left_ff, left_in;
   logic                in_payload_ff, in_payload_in;
   logic [7:0]          avail_ff, avail_in;
   logic                frame_ready_ff, frame_ready_in;
   logic [7:0]          remain_ff, remain_in;
   logic [7:0]          size_ff, size_in;
   logic                meta_valid_ff, meta_valid_in;
   lpfrx_pkg::meta_type meta_ff, meta_in;

   logic          accept;
   logic          size_ok;
   logic [PW-1:0] wr_ptr_inc;
   logic [PW-1:0] rd_ptr_inc;

   assign req_ready = (state_ff == ST_IDLE) && room;
   assign accept    = req_valid && req_ready;
   assign size_ok   = (req_read_size != 8'd0) && (req_read_size <= 8'(BUF_DEPTH));

   assign wr_ptr_inc = (wr_ptr_ff == PW'(BUF_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_inc = (rd_ptr_ff == PW'(BUF_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   assign wr_addr = wr_ptr_ff;
   assign wr_data = req_rx_byte;
   assign rd_addr = rd_ptr_ff;

   always_comb begin
      state_in       = state_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      left_in        = left_ff;
      in_payload_in  = in_payload_ff;
      avail_in       = avail_ff;
      frame_ready_in = frame_ready_ff;
      remain_in      = remain_ff;
      size_in        = size_ff;
      meta_valid_in  = 1'b0;
      meta_in        = '0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (lpfrx_pkg::req_code_type'(req_type))
                  lpfrx_pkg::REQ_RX_BYTE: begin
                     if (!in_payload_ff) begin
                        if (req_rx_byte != 8'd0) begin
                           avail_in      = req_rx_byte;
                           left_in       = req_rx_byte;
                           in_payload_in = 1'b1;
                        end
                     end else begin
                        wr_en     = 1'b1;
                        wr_ptr_in = wr_ptr_inc;
                        left_in   = left_ff - 8'd1;
                        if (left_ff == 8'd1) begin
                           in_payload_in  = 1'b0;
                           frame_ready_in = 1'b1;
                        end
                     end
                  end
                  lpfrx_pkg::REQ_READ: begin
                     meta_valid_in = 1'b1;
                     if (!size_ok) begin
                        meta_in = '{status: 1'b1, received_count: 8'd0,
                                    data_valid: 1'b0, last: 1'b1};
                     end else if (!frame_ready_ff) begin
                        meta_in = '{status: 1'b0, received_count: 8'd0,
                                    data_valid: 1'b0, last: 1'b1};
                     end else if (avail_ff < req_read_size) begin
                        meta_in = '{status: 1'b0, received_count: avail_ff,
                                    data_valid: 1'b0, last: 1'b1};
                     end else begin
                        // first byte goes out now, the rest in ST_DELIVER
                        avail_in = avail_ff - req_read_size;
                        if (avail_ff == req_read_size) begin
                           frame_ready_in = 1'b0;
                        end
                        rd_en     = 1'b1;
                        rd_ptr_in = rd_ptr_inc;
                        meta_in   = '{status: 1'b0, received_count: req_read_size,
                                      data_valid: 1'b1,
                                      last: (req_read_size == 8'd1)};
                        remain_in = req_read_size - 8'd1;
                        size_in   = req_read_size;
                        if (req_read_size != 8'd1) begin
                           state_in = ST_DELIVER;
                        end
                     end
                  end
                  lpfrx_pkg::REQ_FLUSH: begin
                     wr_ptr_in      = '0;
                     rd_ptr_in      = '0;
                     left_in        = 8'd0;
                     in_payload_in  = 1'b0;
                     avail_in       = 8'd0;
                     frame_ready_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DELIVER: begin
            if (room) begin
               rd_en         = 1'b1;
               rd_ptr_in     = rd_ptr_inc;
               meta_valid_in = 1'b1;
               meta_in       = '{status: 1'b0, received_count: size_ff,
                                 data_valid: 1'b1, last: (remain_ff == 8'd1)};
               remain_in     = remain_ff - 8'd1;
               if (remain_ff == 8'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         left_ff        <= 8'd0;
         in_payload_ff  <= 1'b0;
         avail_ff       <= 8'd0;
         frame_ready_ff <= 1'b0;
         remain_ff      <= 8'd0;
         size_ff        <= 8'd0;
         meta_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         left_ff        <= left_in;
         in_payload_ff  <= in_payload_in;
         avail_ff       <= avail_in;
         frame_ready_ff <= frame_ready_in;
         remain_ff      <= remain_in;
         size_ff        <= size_in;
         meta_valid_ff  <= meta_valid_in;
      end
      meta_ff <= meta_in;
   end

   assign meta_valid = meta_valid_ff;
   assign meta       = meta_ff;

endmodule

`default_nettype wire

/* rtl/lpfrx_outq.sv */
// Two-entry result queue; merges store data into issued results.
`default_nettype none

module lpfrx_outq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire lpfrx_pkg::meta_type      meta,
   input  wire logic [7:0]               rd_data,
   output logic                          room,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output lpfrx_pkg::rsp_item_type       item
);

   lpfrx_pkg::rsp_item_type entry_ff [2];
   lpfrx_pkg::rsp_item_type push_item;
   logic                    wr_idx_ff, wr_idx_in;
   logic                    rd_idx_ff, rd_idx_in;
   logic [1:0]              count_ff, count_in;
   logic                    pop;

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      push_item.status         = meta.status;
      push_item.received_count = meta.received_count;
      push_item.data_valid     = meta.data_valid;
      push_item.data_byte      = meta.data_valid ? rd_data : 8'h00;
      push_item.last           = meta.last;
   end

   assign wr_idx_in = push ? ~wr_idx_ff : wr_idx_ff;
   assign rd_idx_in = pop ? ~rd_idx_ff : rd_idx_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   // room: an item issued this cycle still fits when it lands next cycle
   assign room      = (count_in != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign item      = entry_ff[rd_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_idx_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/length_prefixed_frame_rx_buffer.sv */
// Path: a read request's first result is registered in the sequencer, then in the
//   result queue, before it shows on rsp_. A read streams one byte per cycle while
//   the queue has room, set by the single read port; no request is taken meanwhile.
// Reset (synchronous): clears pointers, counts, flags, result queue and store valid
//   bits, so the store reads as zeros until written; no clearing pass is needed.
`default_nettype none

module length_prefixed_frame_rx_buffer #(
   parameter int BUF_DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [7:0] req_read_size,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_status,
   output logic [7:0]      rsp_received_count,
   output logic            rsp_data_valid,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_last
);

   localparam int PW = $clog2(BUF_DEPTH);

   // store ports
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // issued result heading into the queue; its data arrives from the store
   // in the same cycle, the cycle after the read was issued
   logic                    meta_valid;
   lpfrx_pkg::meta_type     meta;
   logic                    room;
   lpfrx_pkg::rsp_item_type item;

   // Sequencer: takes one request at a time. Received bytes either load a nonzero frame
   // length or are written to the store; a read either answers with a single status item
   // or streams N bytes out of the store; a flush clears pointers and counts.
   lpfrx_ctrl #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_rx_byte   (req_rx_byte),
      .req_read_size (req_read_size),
      .room          (room),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .meta_valid    (meta_valid),
      .meta          (meta)
   );

   // Circular payload store with a registered read port.
   lpfrx_mem #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result queue: decouples rsp_ready from the sequencer, so a waiting
   // result does not block the next request, and keeps bytes streaming at
   // one per cycle while the consumer keeps up.
   lpfrx_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (meta_valid),
      .meta      (meta),
      .rd_data   (rd_data),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .item      (item)
   );

   assign rsp_status         = item.status;
   assign rsp_received_count = item.received_count;
   assign rsp_data_valid     = item.data_valid;
   assign rsp_data_byte      = item.data_byte;
   assign rsp_last           = item.last;

endmodule

`default_nettype wire

/* rtl/lpfrx_checker.sv */
// Port-level checker for the frame receive buffer, bound to the top level.
`default_nettype none

`include "length_prefixed_frame_rx_buffer_macros.svh"

module lpfrx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_status,
   input wire logic [7:0] rsp_received_count,
   input wire logic       rsp_data_valid,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_last
);

   `LPFRX_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_received_count), "rsp item changed while stalled")
   `LPFRX_ASSERT_NOW(a_status_only, rsp_valid && !rsp_data_valid, rsp_last && (rsp_data_byte == 8'h00), "status item not last or data nonzero")
   `LPFRX_ASSERT_NOW(a_bad_size, rsp_valid && rsp_status, !rsp_data_valid && (rsp_received_count == 8'd0), "bad-size item carries data or count")
   `LPFRX_ASSERT_NOW(a_data_count, rsp_valid && rsp_data_valid, !rsp_status && (rsp_received_count != 8'd0), "data item with error or zero count")

endmodule

bind length_prefixed_frame_rx_buffer lpfrx_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_received_count (rsp_received_count),
   .rsp_data_valid     (rsp_data_valid),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_last           (rsp_last)
);

`default_nettype wire
